// ===== src/lzw_dig_pkg.sv =====
// ----------------------------------------------------------------------------
// lzw_dig_pkg
// Shared types and constants of the decimal-digit LZW encoder.
// ----------------------------------------------------------------------------
package lzw_dig_pkg;

  // Field widths
  localparam int unsigned SYM_W  = 4;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned NFC_W  = 9;

  // Alphabet: digits 0 to 9 and the point
  localparam int unsigned ALPHA = 11;
  localparam logic [SYM_W-1:0] POINT_SYM = 4'd10;

  // Code numbering skips over the point symbol
  localparam logic [NFC_W-1:0] SKIP_FROM = 9'd9;
  localparam logic [NFC_W-1:0] SKIP_TO   = 9'd11;

  // Configuration register indexes
  localparam logic CFG_FIRST_CODE = 1'b0;
  localparam logic CFG_CODE_LIMIT = 1'b1;

  // Control states
  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  // One child slot of a dictionary row
  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code;
  } slot_t;

  // A dictionary row: one slot per symbol
  typedef slot_t [ALPHA-1:0] row_t;

  // Match result passed along the cell chain
  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } chain_t;

  // Control from the sequencer to the dictionary
  typedef struct packed {
    logic              rd_en;
    logic [CODE_W-1:0] rd_code;
    logic [SYM_W-1:0]  sym;
    logic              ins_en;
    logic [CODE_W-1:0] ins_code;
    logic              clr_en;
    logic [CODE_W-1:0] clr_code;
    logic              flush;
  } dict_req_t;

  // Lookup answer from the dictionary
  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } dict_rsp_t;

  // One queued result
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eos;
    logic              full;
  } result_t;

endpackage

// ===== src/lzw_dig_cell.sv =====
// ----------------------------------------------------------------------------
// lzw_dig_cell
// One child slot of the dictionary row: match, chain merge and row update.
// ----------------------------------------------------------------------------
module lzw_dig_cell #(
  parameter int unsigned SLOT = 0
) (
  input  lzw_dig_pkg::slot_t                       slot_i,
  input  logic                                     row_ok_i,
  input  logic [lzw_dig_pkg::SYM_W-1:0]            sym_i,
  input  logic [lzw_dig_pkg::CODE_W-1:0]           ins_code_i,
  input  lzw_dig_pkg::chain_t                      chain_i,
  output lzw_dig_pkg::chain_t                      chain_o,
  output lzw_dig_pkg::slot_t                       slot_o
);

  logic sel;
  logic own_vld;
  logic hit_here;

  // Select this slot and qualify its stored valid bit
  assign sel      = (sym_i == lzw_dig_pkg::SYM_W'(SLOT));
  assign own_vld  = slot_i.vld & row_ok_i;
  assign hit_here = sel & own_vld;

  // Merge own match into the result handed to the next cell
  assign chain_o.hit  = chain_i.hit | hit_here;
  assign chain_o.code = chain_i.code | (hit_here ? slot_i.code : '0);

  // Build the written-back slot: insert on the selected one
  assign slot_o.vld  = own_vld | sel;
  assign slot_o.code = sel ? ins_code_i : slot_i.code;

endmodule

// ===== src/lzw_dig_dict.sv =====
// ----------------------------------------------------------------------------
// lzw_dig_dict
// Dictionary store: one row per prefix code, one chain of slot cells for the row read.
// ----------------------------------------------------------------------------
module lzw_dig_dict #(
  parameter int unsigned MAX_CODES = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lzw_dig_pkg::dict_req_t req_i,
  output lzw_dig_pkg::dict_rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(MAX_CODES);
  localparam int unsigned LW = $clog2(lzw_dig_pkg::ALPHA);

  lzw_dig_pkg::row_t                  mem_q [MAX_CODES];
  lzw_dig_pkg::row_t                  rd_q;
  logic [lzw_dig_pkg::CODE_W-1:0]     rd_code_q;
  logic [lzw_dig_pkg::ALPHA-1:0]      low_vld_q;
  logic                               rd_low;
  logic                               row_ok;
  lzw_dig_pkg::chain_t                chain [lzw_dig_pkg::ALPHA+1];
  lzw_dig_pkg::row_t                  wr_row;

  // Rows of symbol codes carry their own valid bit; higher rows are cleared
  // when their code is handed out
  assign rd_low = (rd_code_q < lzw_dig_pkg::CODE_W'(lzw_dig_pkg::ALPHA));
  assign row_ok = rd_low ? low_vld_q[rd_code_q[LW-1:0]] : 1'b1;

  // Chain of slot cells
  assign chain[0] = '0;
  for (genvar g = 0; g < lzw_dig_pkg::ALPHA; g++) begin : g_cell
    lzw_dig_cell #(
      .SLOT (g)
    ) u_cell (
      .slot_i     (rd_q[g]),
      .row_ok_i   (row_ok),
      .sym_i      (req_i.sym),
      .ins_code_i (req_i.ins_code),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1]),
      .slot_o     (wr_row[g])
    );
  end

  assign rsp_o.hit  = chain[lzw_dig_pkg::ALPHA].hit;
  assign rsp_o.code = chain[lzw_dig_pkg::ALPHA].code;

  // Memory write port: row update on insert, otherwise a pending clear
  always_ff @(posedge clk_i) begin
    if (req_i.ins_en) begin
      mem_q[AW'(rd_code_q)] <= wr_row;
    end else if (req_i.clr_en) begin
      mem_q[AW'(req_i.clr_code)] <= '0;
    end
  end

  // Registered row read at the current code
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q      <= mem_q[AW'(req_i.rd_code)];
      rd_code_q <= req_i.rd_code;
    end
  end

  // Row valid bits of the symbol rows, dropped at end of stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_vld_q <= '0;
    end else if (req_i.flush) begin
      low_vld_q <= '0;
    end else if (req_i.ins_en && rd_low) begin
      low_vld_q[rd_code_q[LW-1:0]] <= 1'b1;
    end
  end

  // Insert and clear never share the write port
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ins_en && req_i.clr_en))
    else $error("dictionary insert and clear in the same cycle");

  // A cleared row is never the one being read at the same edge
  a_clr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.clr_en && req_i.rd_en) |-> (req_i.clr_code != req_i.rd_code))
    else $error("dictionary row read while being cleared");

  // Cleared rows are never symbol rows
  a_clr_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clr_en |-> (req_i.clr_code >= lzw_dig_pkg::CODE_W'(lzw_dig_pkg::ALPHA)))
    else $error("clear issued for a symbol row");

endmodule

// ===== src/lzw_digit_encoder.sv =====
// ----------------------------------------------------------------------------
// lzw_digit_encoder
// LZW encoder for streams of decimal digits and the point.
// ----------------------------------------------------------------------------
// Symbols enter on the s_axis channel (tdata[3:0] symbol, tlast ends the
// stream); code words leave on m_axis (tdata code, tlast end of stream,
// tuser dictionary full). Registers are written on the cfg channel:
// index 0 first code of a stream, index 1 largest code that may be given.
// For each symbol, the dictionary row of the current code is read in the
// accepting cycle and the slot chain decides hit or insert in the next;
// the following lookup must see the code and row that this one left, so
// no symbol is taken while one is being evaluated. A result is queued
// when its symbol is evaluated, and a symbol gives at most two. A
// four-entry result queue lets symbols keep flowing while the receiver
// stalls; input is also held off when fewer than two places remain.
// Reset leaves the encoder at the start of a stream with an empty dictionary
// and registers at 11 and 255; no clearing pass is needed, as high rows are
// wiped as their code is handed out.
// ----------------------------------------------------------------------------
module lzw_digit_encoder #(
  parameter int unsigned MAX_CODES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Symbol input
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] symbol, [7:4] unused
  input  logic       s_axis_tlast,
  // Code output
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] code
  output logic       m_axis_tlast,
  output logic       m_axis_tuser,   // [0] dictionary_full
  // Configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam logic [12:0] MaxCodesW = 13'(MAX_CODES);

  lzw_dig_pkg::state_e                state_q, state_d;
  logic [lzw_dig_pkg::CODE_W-1:0]     first_code_q, code_limit_q;
  logic [lzw_dig_pkg::SYM_W-1:0]      sym_q, sym_sat;
  logic                               last_q;
  logic [lzw_dig_pkg::CODE_W-1:0]     cur_q, cur_d;
  logic                               have_q, have_d;
  logic [lzw_dig_pkg::NFC_W-1:0]      nfc_q, nfc_d;
  logic                               abort_q, abort_d;
  logic                               clr_q, clr_d;
  logic [lzw_dig_pkg::CODE_W-1:0]     clr_code_q;
  logic                               accept, eval, ins_en, flush, full_cond, miss_full;
  lzw_dig_pkg::dict_req_t             req;
  lzw_dig_pkg::dict_rsp_t             rsp;
  lzw_dig_pkg::result_t               res0, res1;
  logic [1:0]                         n_push;
  lzw_dig_pkg::result_t               buf_q [4];
  logic [1:0]                         wr_ptr_q, rd_ptr_q;
  logic [2:0]                         cnt_q;
  logic                               pop, room;

  // Handshakes
  assign room          = (cnt_q <= 3'd2);
  assign s_axis_tready = (state_q == lzw_dig_pkg::ST_IDLE) && room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign eval          = (state_q == lzw_dig_pkg::ST_EVAL);
  assign cfg_ready_o   = 1'b1;
  assign pop           = m_axis_tvalid && m_axis_tready;

  // Clamp symbols above the point
  assign sym_sat = (s_axis_tdata[lzw_dig_pkg::SYM_W-1:0] > lzw_dig_pkg::POINT_SYM) ?
                   lzw_dig_pkg::POINT_SYM : s_axis_tdata[lzw_dig_pkg::SYM_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzw_dig_pkg::ST_IDLE: if (accept) state_d = lzw_dig_pkg::ST_EVAL;
      lzw_dig_pkg::ST_EVAL: state_d = lzw_dig_pkg::ST_IDLE;
      default:              state_d = lzw_dig_pkg::ST_IDLE;
    endcase
  end

  // Dictionary full when the next code is over the limit or out of rows
  assign full_cond = (nfc_q > {1'b0, code_limit_q}) || ({4'b0, nfc_q} >= MaxCodesW);

  // Evaluate one symbol against the looked-up row
  always_comb begin
    cur_d     = cur_q;
    have_d    = have_q;
    nfc_d     = nfc_q;
    abort_d   = abort_q;
    ins_en    = 1'b0;
    clr_d     = 1'b0;
    flush     = 1'b0;
    miss_full = 1'b0;
    n_push    = 2'd0;
    res0      = '0;
    res1      = '0;
    if (eval) begin
      if (abort_q) begin
        flush = last_q;
      end else begin
        if (!have_q) begin
          cur_d  = {{(lzw_dig_pkg::CODE_W-lzw_dig_pkg::SYM_W){1'b0}}, sym_q};
          have_d = 1'b1;
          nfc_d  = {1'b0, first_code_q};
        end else if (rsp.hit) begin
          cur_d = rsp.code;
        end else if (full_cond) begin
          res0      = '{code: '0, eos: 1'b1, full: 1'b1};
          n_push    = 2'd1;
          abort_d   = 1'b1;
          miss_full = 1'b1;
          flush     = last_q;
        end else begin
          ins_en = 1'b1;
          nfc_d  = (nfc_q == lzw_dig_pkg::SKIP_FROM) ? lzw_dig_pkg::SKIP_TO :
                   nfc_q + 1'b1;
          res0   = '{code: cur_q, eos: 1'b0, full: 1'b0};
          n_push = 2'd1;
          cur_d  = {{(lzw_dig_pkg::CODE_W-lzw_dig_pkg::SYM_W){1'b0}}, sym_q};
          clr_d  = (nfc_q >= lzw_dig_pkg::NFC_W'(lzw_dig_pkg::ALPHA));
        end
        // Flush the final code at the end of the stream
        if (last_q && !miss_full) begin
          if (n_push == 2'd1) begin
            res1 = '{code: cur_d, eos: 1'b1, full: 1'b0};
          end else begin
            res0 = '{code: cur_d, eos: 1'b1, full: 1'b0};
          end
          n_push = n_push + 2'd1;
          flush  = 1'b1;
        end
      end
      if (flush) begin
        cur_d   = '0;
        have_d  = 1'b0;
        nfc_d   = {1'b0, first_code_q};
        abort_d = 1'b0;
      end
    end
  end

  // Dictionary request
  always_comb begin
    req.rd_en    = accept;
    req.rd_code  = cur_q;
    req.sym      = sym_q;
    req.ins_en   = ins_en;
    req.ins_code = nfc_q[lzw_dig_pkg::CODE_W-1:0];
    req.clr_en   = clr_q;
    req.clr_code = clr_code_q;
    req.flush    = flush;
  end

  lzw_dig_dict #(
    .MAX_CODES (MAX_CODES)
  ) u_dict (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Control and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lzw_dig_pkg::ST_IDLE;
      first_code_q <= 8'd11;
      code_limit_q <= 8'd255;
      cur_q        <= '0;
      have_q       <= 1'b0;
      nfc_q        <= 9'd11;
      abort_q      <= 1'b0;
      clr_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      have_q  <= have_d;
      nfc_q   <= nfc_d;
      abort_q <= abort_d;
      clr_q   <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          lzw_dig_pkg::CFG_FIRST_CODE: first_code_q <= cfg_data_i;
          lzw_dig_pkg::CFG_CODE_LIMIT: code_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Hold the accepted symbol and the code whose row is to be wiped
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q  <= sym_sat;
      last_q <= s_axis_tlast;
    end
    if (clr_d) begin
      clr_code_q <= nfc_q[lzw_dig_pkg::CODE_W-1:0];
    end
  end

  // Result queue payload
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      buf_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      buf_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      cnt_q    <= cnt_q + {1'b0, n_push} - {2'b0, pop};
    end
  end

  // Drive the output channel from the queue head
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tdata  = buf_q[rd_ptr_q].code;
  assign m_axis_tlast  = buf_q[rd_ptr_q].eos;
  assign m_axis_tuser  = buf_q[rd_ptr_q].full;

  // Evaluation always finds room for two results
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval |-> (cnt_q <= 3'd2))
    else $error("result queue lacks room at evaluation");

  // Queue never overflows
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue overflow");

  // An aborted stream has started
  a_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    abort_q |-> have_q)
    else $error("abort outside a stream");

  // A pending row clear follows an insert
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> $past(ins_en))
    else $error("row clear without an insert");

endmodule

// ===== tb/sv/lzw_digit_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// lzw_digit_encoder_tb
// Self-checking bench for the decimal-digit LZW encoder. Symbol streams are
// queued by a stimulus process, presented by a driver with random gaps and
// checked against a bench-side dictionary model as code words leave the
// block under random back-pressure. Registers are rewritten between phases
// to cover numbering skips, limit errors and aborted streams.
// ----------------------------------------------------------------------------
module lzw_digit_encoder_tb;

  localparam int unsigned TB_MAX_CODES = 256;
  localparam int unsigned DICT_DEPTH   = TB_MAX_CODES * lzw_dig_pkg::ALPHA;
  localparam int unsigned SETTLE_CYC   = 10;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [lzw_dig_pkg::SYM_W-1:0] sym;
    logic                          last;
  } symbol_item_t;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;  // [3:0] symbol, [7:4] zero
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] code
  logic       m_axis_tlast;
  logic       m_axis_tuser;        // [0] dictionary_full
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i  = '0;

  // Register mirror
  logic [lzw_dig_pkg::CODE_W-1:0] first_code_q = 8'd11;
  logic [lzw_dig_pkg::CODE_W-1:0] code_limit_q = 8'd255;

  // Dictionary model
  logic [lzw_dig_pkg::CODE_W-1:0] cur_code  = '0;
  logic                           have_code = 1'b0;
  logic [lzw_dig_pkg::NFC_W-1:0]  next_free = 9'd11;
  logic                           aborted   = 1'b0;
  logic [lzw_dig_pkg::CODE_W-1:0] dict_code [DICT_DEPTH];
  logic                           dict_vld  [DICT_DEPTH];

  symbol_item_t         symbol_q[$];
  lzw_dig_pkg::result_t expected_codes[$];

  // Driver and receiver state
  symbol_item_t cur_item = '0;
  logic         src_busy = 1'b0;
  int           src_wait = 0;
  int           src_gap_max = 0;
  logic         snk_took = 1'b0;
  int           snk_wait = 0;
  int           snk_gap_max = 0;

  int n_errors    = 0;
  int cycle_count = 0;
  int queued      = 0;

  lzw_digit_encoder #(
    .MAX_CODES(TB_MAX_CODES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < DICT_DEPTH; i++) begin
      dict_vld[i]  = 1'b0;
      dict_code[i] = '0;
    end
  end

  // Empty the dictionary and return to the start of a stream
  function automatic void close_stream();
    for (int i = 0; i < DICT_DEPTH; i++) dict_vld[i] = 1'b0;
    cur_code  = '0;
    have_code = 1'b0;
    next_free = lzw_dig_pkg::NFC_W'(first_code_q);
    aborted   = 1'b0;
  endfunction

  // Advance the dictionary model by one symbol and queue the codes it emits
  function automatic void encode_symbol(input logic [lzw_dig_pkg::SYM_W-1:0] sym_in,
                                        input logic last_in);
    logic [lzw_dig_pkg::SYM_W-1:0] sym;
    int                            slot;
    sym = (sym_in > lzw_dig_pkg::POINT_SYM) ? lzw_dig_pkg::POINT_SYM : sym_in;
    if (aborted) begin
      if (last_in) close_stream();
      return;
    end
    if (!have_code) begin
      cur_code  = lzw_dig_pkg::CODE_W'(sym);
      have_code = 1'b1;
      next_free = lzw_dig_pkg::NFC_W'(first_code_q);
    end else begin
      slot = int'(cur_code) * lzw_dig_pkg::ALPHA + int'(sym);
      if (dict_vld[slot]) begin
        cur_code = dict_code[slot];
      end else if (next_free > {1'b0, code_limit_q} || next_free >= TB_MAX_CODES) begin
        // No code left: report once and drop the rest of the stream
        expected_codes.push_back(
          lzw_dig_pkg::result_t'{code: '0, eos: 1'b1, full: 1'b1});
        aborted = 1'b1;
        if (last_in) close_stream();
        return;
      end else begin
        dict_code[slot] = next_free[lzw_dig_pkg::CODE_W-1:0];
        dict_vld[slot]  = 1'b1;
        next_free = (next_free == lzw_dig_pkg::SKIP_FROM) ? lzw_dig_pkg::SKIP_TO :
                    next_free + 1'b1;
        expected_codes.push_back(
          lzw_dig_pkg::result_t'{code: cur_code, eos: 1'b0, full: 1'b0});
        cur_code = lzw_dig_pkg::CODE_W'(sym);
      end
    end
    if (last_in) begin
      expected_codes.push_back(
        lzw_dig_pkg::result_t'{code: cur_code, eos: 1'b1, full: 1'b0});
      close_stream();
    end
  endfunction

  // Symbol driver: take the next item once the gap has run out
  always @(negedge clk_i) begin
    if (rst_ni && !src_busy) begin
      if (src_wait > 0) begin
        src_wait--;
      end else if (symbol_q.size() != 0) begin
        cur_item = symbol_q.pop_front();
        src_busy = 1'b1;
        src_wait = $urandom_range(0, src_gap_max);
      end
    end
    s_axis_tvalid <= src_busy;
    s_axis_tdata  <= {4'b0000, cur_item.sym};
    s_axis_tlast  <= cur_item.last;
  end

  // Predict on every accepted symbol transaction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      encode_symbol(s_axis_tdata[lzw_dig_pkg::SYM_W-1:0], s_axis_tlast);
      src_busy = 1'b0;
    end
  end

  // Receiver back-pressure: stall for a random gap, up to snk_gap_max, after each code word
  always @(negedge clk_i) begin
    if (snk_took) begin
      snk_took = 1'b0;
      snk_wait = $urandom_range(0, snk_gap_max);
    end
    if (snk_wait > 0) begin
      snk_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every accepted code word with the oldest expectation
  always @(posedge clk_i) begin
    lzw_dig_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      snk_took = 1'b1;
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected code word, expected none, got code %0d eos %0b full %0b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        n_errors++;
      end else begin
        want = expected_codes.pop_front();
        if (m_axis_tdata !== want.code) begin
          $display("%0t: code mismatch, expected %0d, got %0d", $time, want.code, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tlast !== want.eos) begin
          $display("%0t: end_of_stream mismatch, expected %0b, got %0b",
                   $time, want.eos, m_axis_tlast);
          n_errors++;
        end
        if (m_axis_tuser !== want.full) begin
          $display("%0t: dictionary_full mismatch, expected %0b, got %0b",
                   $time, want.full, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == lzw_dig_pkg::CFG_FIRST_CODE) first_code_q = val;
    else code_limit_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every symbol is taken and every code word has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    while (symbol_q.size() != 0 || src_busy || expected_codes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic push_symbol(input logic [lzw_dig_pkg::SYM_W-1:0] sym, input logic last);
    symbol_q.push_back(symbol_item_t'{sym: sym, last: last});
    queued++;
  endtask

  // Queue symbols held as nibbles, first symbol in the lowest nibble
  task automatic queue_symbols(input logic [63:0] nibbles, input int count, input logic close);
    for (int i = 0; i < count; i++)
      push_symbol(nibbles[i*4 +: 4], close && (i == count - 1));
  endtask

  task automatic write_both(input logic [7:0] fc, input logic [7:0] cl);
    if ($urandom_range(0, 1) != 0) begin
      write_reg(lzw_dig_pkg::CFG_FIRST_CODE, fc);
      write_reg(lzw_dig_pkg::CFG_CODE_LIMIT, cl);
    end else begin
      write_reg(lzw_dig_pkg::CFG_CODE_LIMIT, cl);
      write_reg(lzw_dig_pkg::CFG_FIRST_CODE, fc);
    end
  endtask

  initial begin
    int          stream_left;
    int          alpha_hi;
    int          phase_len;
    logic [7:0]  fc;
    logic [7:0]  cl;
    logic [3:0]  sym;
    stream_left = 0;
    alpha_hi    = 10;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: leading point, saturated symbol, hits after misses, defaults
    src_gap_max = 3;
    snk_gap_max = 3;
    queue_symbols(64'h1C1A1A, 6, 1'b1);
    queue_symbols(64'h9, 1, 1'b1);
    wait_drained();
    // Numbering skips the point code, then the limit trips on the last symbol
    write_both(8'd8, 8'd12);
    queue_symbols(64'h543210, 6, 1'b1);
    wait_drained();
    // Top code, abort mid-stream with ignored symbols, then recovery
    write_both(8'd255, 8'd255);
    queue_symbols(64'h43210, 5, 1'b1);
    queue_symbols(64'hFF, 2, 1'b1);
    wait_drained();
    // Lowest settings; limit change mid-stream applies at once
    write_both(8'd0, 8'd0);
    queue_symbols(64'h543, 3, 1'b1);
    queue_symbols(64'h21, 2, 1'b0);
    wait_drained();
    write_reg(lzw_dig_pkg::CFG_CODE_LIMIT, 8'd255);
    write_reg(lzw_dig_pkg::CFG_FIRST_CODE, 8'd11);
    queue_symbols(64'h3, 1, 1'b1);

    // Random phases: fresh settings, streams of random length and alphabet
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0: begin fc = 8'd11; cl = 8'd255; end
        1: begin fc = 8'($urandom_range(0, 255)); cl = 8'($urandom_range(0, 255)); end
        2: begin fc = 8'd0; cl = 8'($urandom_range(0, 40)); end
        3: begin fc = 8'($urandom_range(240, 255)); cl = 8'd255; end
        4: begin
          fc = 8'($urandom_range(0, 20));
          cl = fc + 8'($urandom_range(0, 30));
        end
        default: begin fc = 8'd255; cl = 8'd0; end
      endcase
      write_both(fc, cl);
      case ($urandom_range(0, 2))
        0: src_gap_max = 0;
        1: src_gap_max = 3;
        default: src_gap_max = 9;
      endcase
      case ($urandom_range(0, 2))
        0: snk_gap_max = 0;
        1: snk_gap_max = 3;
        default: snk_gap_max = 9;
      endcase
      phase_len = $urandom_range(30, 90);
      repeat (phase_len) begin
        if (stream_left == 0) begin
          stream_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
          case ($urandom_range(0, 4))
            0: alpha_hi = 1;
            1: alpha_hi = 2;
            2: alpha_hi = 3;
            default: alpha_hi = 10;
          endcase
        end
        sym = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(11, 15))
                                           : 4'($urandom_range(0, alpha_hi));
        stream_left--;
        push_symbol(sym, stream_left == 0);
      end
    end
    if (stream_left != 0) push_symbol(4'($urandom_range(0, 10)), 1'b1);

    wait_drained();
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
